[hw/rtl/cdwi_pkg.sv]
// ----------------------------------------------------------------------------
// cdwi_pkg
// Shared widths, codes and controller/datapath interface types for the coil
// drive waveform interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cdwi_pkg;

  localparam int TIME_W  = 31;
  localparam int CUR_W   = 32;
  localparam int DELTA_W = 35;
  localparam int X_W     = 34;
  localparam int Q_W     = 24;
  localparam int PROD_W  = 64;
  localparam int QUO_W   = 33;
  localparam int CNT_W   = 6;
  localparam int PT_AW   = 8;
  localparam int CO_AW   = 6;
  localparam int NPT_W   = 9;
  localparam int NCO_W   = 7;

  localparam logic [1:0] CMD_LOAD_TIME = 2'd0;
  localparam logic [1:0] CMD_LOAD_CUR  = 2'd1;
  localparam logic [1:0] CMD_EVAL      = 2'd2;

  localparam logic [1:0] REG_POINTS = 2'd0;
  localparam logic [1:0] REG_COILS  = 2'd1;
  localparam logic [1:0] REG_QSTEP  = 2'd2;
  localparam logic [1:0] REG_TRAP   = 2'd3;

  // sample offsets from t, in quarter steps
  typedef enum logic [2:0] {
    PT_P5 = 3'd0,
    PT_P3 = 3'd1,
    PT_P1 = 3'd2,
    PT_M1 = 3'd3,
    PT_P4 = 3'd4
  } pt_t;

  typedef struct packed {
    logic [4:0]     points;
    logic [3:0]     coils;
    logic [Q_W-1:0] qstep;
    logic           trap;
  } cfg_t;

  typedef struct packed {
    logic             eval_start;
    logic             load_x;
    pt_t              pt;
    logic             t_rd;
    logic [PT_AW-1:0] t_addr;
    logic             save_prev;
    logic             save_seg;
    logic             c_rd;
    logic [CO_AW-1:0] c_coil;
    logic [PT_AW-1:0] c_addr;
    logic             save_v0;
    logic             save_v1;
    logic             do_mul;
    logic             div_start;
    logic             take_clamp;
    logic             take_interp;
    logic             acc_en;
    logic             emit;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic x_le;
    logic x_ge;
    logic in_seg;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/cdwi_div.sv]
// ----------------------------------------------------------------------------
// cdwi_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit QUO_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cdwi_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cdwi_pkg::PROD_W-1:0] dividend,
  input  wire logic [cdwi_pkg::TIME_W-1:0] divisor,
  output logic                             busy,
  output logic [cdwi_pkg::QUO_W-1:0]       quotient
);
  import cdwi_pkg::*;

  logic [TIME_W-1:0] rem;
  logic [QUO_W-1:0]  sh;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign trial    = {rem, sh[QUO_W-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:QUO_W];
      sh  <= dividend[QUO_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      sh  <= {sh[QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cdwi_dp.sv]
// ----------------------------------------------------------------------------
// cdwi_dp
// Datapath: breakpoint memories, sample time, segment search compares,
// interpolation multiply and divide, drive accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdwi_dp #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_COILS  = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cdwi_pkg::cfg_t              cfg,
  input  wire cdwi_pkg::dp_cmd_t           cmd,
  output cdwi_pkg::dp_stat_t               stat,
  input  wire logic                        in_fire,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [3:0]                  in_point,
  input  wire logic [2:0]                  in_coil,
  input  wire logic [31:0]                 in_value,
  input  wire logic [cdwi_pkg::TIME_W-1:0] in_time,
  output logic                             m_valid,
  input  wire logic                        m_ready,
  output logic [71:0]                      m_data,
  output logic                             m_last
);
  import cdwi_pkg::*;

  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;

  logic [TIME_W-1:0]        time_mem [MAX_POINTS];
  logic signed [CUR_W-1:0]  cur_mem  [MAX_COILS][MAX_POINTS];
  logic [TIME_W-1:0]        tdata;
  logic signed [CUR_W-1:0]  cdata;

  logic [PT_AW-1:0] wpt;
  logic [CO_AW-1:0] wco;
  logic             pt_ok;
  logic             co_ok;

  assign wpt   = PT_AW'(in_point);
  assign wco   = CO_AW'(in_coil);
  assign pt_ok = NPT_W'(in_point) < NPT_W'(MAX_POINTS);
  assign co_ok = NCO_W'(in_coil) < NCO_W'(MAX_COILS);

  always_ff @(posedge clk) begin
    if (in_fire && in_cmd == CMD_LOAD_TIME && pt_ok) begin
      time_mem[wpt[PW-1:0]] <= in_value[TIME_W-1:0];
    end
    if (cmd.t_rd) begin
      tdata <= time_mem[cmd.t_addr[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_cmd == CMD_LOAD_CUR && pt_ok && co_ok) begin
      cur_mem[wco[CW-1:0]][wpt[PW-1:0]] <= in_value;
    end
    if (cmd.c_rd) begin
      cdata <= cur_mem[cmd.c_coil[CW-1:0]][cmd.c_addr[PW-1:0]];
    end
  end

  logic [TIME_W-1:0]        t_reg;
  logic signed [X_W-1:0]    x;
  logic signed [X_W-1:0]    qs;
  logic signed [X_W-1:0]    mq;
  logic signed [X_W-1:0]    tx;
  logic signed [X_W-1:0]    px;
  logic signed [X_W-1:0]    t0x;
  logic [TIME_W-1:0]        prev;
  logic [TIME_W-1:0]        t0;
  logic [TIME_W-1:0]        t1;
  logic signed [CUR_W-1:0]  v0;
  logic signed [CUR_W-1:0]  v1;
  logic signed [CUR_W:0]    dv;
  logic [CUR_W:0]           mag;
  logic signed [X_W-1:0]    dspan_x;
  logic [TIME_W-1:0]        dspan;
  logic [TIME_W-1:0]        den;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_next;
  logic                     neg;
  logic [QUO_W-1:0]         quo;
  logic                     div_busy;
  logic signed [CUR_W+1:0]  sv0;
  logic signed [CUR_W+1:0]  squo;
  logic signed [CUR_W+1:0]  res;
  logic signed [CUR_W-1:0]  value;
  logic signed [DELTA_W-1:0] acc;
  logic signed [DELTA_W-1:0] vx;
  logic signed [DELTA_W-1:0] vs;
  logic signed [CUR_W-1:0]  end_cur;

  assign qs = $signed({{(X_W-Q_W){1'b0}}, cfg.qstep});

  always_comb begin
    case (cmd.pt)
      PT_P5:   mq = (qs <<< 2) + qs;
      PT_P3:   mq = (qs <<< 1) + qs;
      PT_P1:   mq = qs;
      PT_M1:   mq = -qs;
      PT_P4:   mq = qs <<< 2;
      default: mq = '0;
    endcase
  end

  assign tx  = $signed({{(X_W-TIME_W){1'b0}}, tdata});
  assign px  = $signed({{(X_W-TIME_W){1'b0}}, prev});
  assign t0x = $signed({{(X_W-TIME_W){1'b0}}, t0});

  assign stat.x_le     = x <= tx;
  assign stat.x_ge     = x >= tx;
  assign stat.in_seg   = (x >= px) && (x < tx);
  assign stat.div_busy = div_busy;
  assign stat.out_free = !m_valid || m_ready;

  assign dv        = {v1[CUR_W-1], v1} - {v0[CUR_W-1], v0};
  assign mag       = dv[CUR_W] ? CUR_W'(0) - dv : dv;
  assign dspan_x   = x - t0x;
  assign dspan     = dspan_x[TIME_W-1:0];
  assign den       = t1 - t0;
  assign prod_next = mag * dspan;

  assign sv0  = (CUR_W+2)'(v0);
  assign squo = $signed({1'b0, quo});
  assign res  = neg ? sv0 - squo : sv0 + squo;

  assign vx = DELTA_W'(value);
  assign vs = cfg.trap ? vx : (vx <<< 1);

  cdwi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (den),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      t_reg <= in_time;
    end
    if (cmd.load_x) begin
      x <= $signed({{(X_W-TIME_W){1'b0}}, t_reg}) + mq;
    end
    if (cmd.save_prev) begin
      prev <= tdata;
    end
    if (cmd.save_seg) begin
      t0 <= prev;
      t1 <= tdata;
    end
    if (cmd.save_v0) begin
      v0 <= cdata;
    end
    if (cmd.save_v1) begin
      v1 <= cdata;
    end
    if (cmd.do_mul) begin
      prod <= prod_next;
      neg  <= dv[CUR_W];
    end
    if (cmd.take_clamp) begin
      value <= cdata;
    end else if (cmd.take_interp) begin
      value <= res[CUR_W-1:0];
    end
    if (cmd.eval_start || cmd.emit) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      case (cmd.pt)
        PT_P5:   acc <= acc + vs;
        PT_P3:   acc <= acc - vs;
        PT_P1:   acc <= acc + vx;
        PT_M1:   acc <= acc - vx;
        PT_P4:   end_cur <= value;
        default: acc <= acc;
      endcase
    end
    if (cmd.emit) begin
      m_data <= {2'b00, end_cur, acc, cmd.c_coil[2:0]};
      m_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cdwi_ctrl.sv]
// ----------------------------------------------------------------------------
// cdwi_ctrl
// Sequencer: walks coils and sample offsets, runs the breakpoint search,
// then the multiply/divide, accumulation and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cdwi_ctrl #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_COILS  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cdwi_pkg::cfg_t    cfg,
  input  wire cdwi_pkg::dp_stat_t stat,
  input  wire logic              in_fire,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_ready,
  output cdwi_pkg::dp_cmd_t      cmd
);
  import cdwi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XSET, S_CHKLO, S_CHKHI, S_SCAN0, S_SCAN, S_RDV0, S_RDV1,
    S_MUL, S_DIVGO, S_DIVWAIT, S_CLAMP, S_ACC, S_EMIT
  } state_t;

  state_t           state;
  logic [PT_AW-1:0] idx;
  logic [CO_AW-1:0] coil;
  pt_t              pt;
  pt_t              pt_next;

  logic [NPT_W-1:0] npts;
  logic [NCO_W-1:0] ncoil;
  logic [PT_AW-1:0] last_pt;
  logic [CO_AW-1:0] last_coil;
  logic             is_last;

  always_comb begin
    if (cfg.points < 5'd2) begin
      npts = NPT_W'(2);
    end else if (NPT_W'(cfg.points) > NPT_W'(MAX_POINTS)) begin
      npts = NPT_W'(MAX_POINTS);
    end else begin
      npts = NPT_W'(cfg.points);
    end
    if (cfg.coils == 4'd0) begin
      ncoil = NCO_W'(1);
    end else if (NCO_W'(cfg.coils) > NCO_W'(MAX_COILS)) begin
      ncoil = NCO_W'(MAX_COILS);
    end else begin
      ncoil = NCO_W'(cfg.coils);
    end
  end

  assign last_pt   = PT_AW'(npts - 1'b1);
  assign last_coil = CO_AW'(ncoil - 1'b1);
  assign is_last   = coil == last_coil;

  // backward mode only needs the +5q, +3q and +4q samples
  always_comb begin
    case (pt)
      PT_P5:   pt_next = PT_P3;
      PT_P3:   pt_next = cfg.trap ? PT_P1 : PT_P4;
      PT_P1:   pt_next = PT_M1;
      default: pt_next = PT_P4;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.pt   = pt;
    cmd.c_coil = coil;
    cmd.last = is_last;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.eval_start = in_fire && in_cmd == CMD_EVAL;
      end
      S_XSET: begin
        cmd.load_x = 1'b1;
        cmd.t_rd   = 1'b1;
      end
      S_CHKLO: begin
        if (stat.x_le) begin
          cmd.c_rd = 1'b1;
        end else begin
          cmd.t_rd   = 1'b1;
          cmd.t_addr = last_pt;
        end
      end
      S_CHKHI: begin
        if (stat.x_ge) begin
          cmd.c_rd   = 1'b1;
          cmd.c_addr = last_pt;
        end else begin
          cmd.t_rd = 1'b1;
        end
      end
      S_SCAN0: begin
        cmd.save_prev = 1'b1;
        cmd.t_rd      = 1'b1;
        cmd.t_addr    = PT_AW'(1);
      end
      S_SCAN: begin
        if (stat.in_seg) begin
          cmd.save_seg = 1'b1;
          cmd.c_rd     = 1'b1;
          cmd.c_addr   = idx - 1'b1;
        end else if (idx == last_pt) begin
          // times not increasing: fall back to the last point
          cmd.c_rd   = 1'b1;
          cmd.c_addr = last_pt;
        end else begin
          cmd.save_prev = 1'b1;
          cmd.t_rd      = 1'b1;
          cmd.t_addr    = idx + 1'b1;
        end
      end
      S_RDV0: begin
        cmd.save_v0 = 1'b1;
        cmd.c_rd    = 1'b1;
        cmd.c_addr  = idx;
      end
      S_RDV1:    cmd.save_v1     = 1'b1;
      S_MUL:     cmd.do_mul      = 1'b1;
      S_DIVGO:   cmd.div_start   = 1'b1;
      S_DIVWAIT: cmd.take_interp = !stat.div_busy;
      S_CLAMP:   cmd.take_clamp  = 1'b1;
      S_ACC:     cmd.acc_en      = 1'b1;
      S_EMIT:    cmd.emit        = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      coil  <= '0;
      pt    <= PT_P5;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_cmd == CMD_EVAL) begin
            coil  <= '0;
            pt    <= PT_P5;
            state <= S_XSET;
          end
        end
        S_XSET:  state <= S_CHKLO;
        S_CHKLO: state <= stat.x_le ? S_CLAMP : S_CHKHI;
        S_CHKHI: state <= stat.x_ge ? S_CLAMP : S_SCAN0;
        S_SCAN0: begin
          idx   <= PT_AW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.in_seg) begin
            state <= S_RDV0;
          end else if (idx == last_pt) begin
            state <= S_CLAMP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RDV0:  state <= S_RDV1;
        S_RDV1:  state <= S_MUL;
        S_MUL:   state <= S_DIVGO;
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (!stat.div_busy) begin
            state <= S_ACC;
          end
        end
        S_CLAMP: state <= S_ACC;
        S_ACC: begin
          if (pt == PT_P4) begin
            state <= S_EMIT;
          end else begin
            pt    <= pt_next;
            state <= S_XSET;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              coil  <= coil + 1'b1;
              pt    <= PT_P5;
              state <= S_XSET;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/coil_drive_waveform_interpolator_top.sv]
// ----------------------------------------------------------------------------
// coil_drive_waveform_interpolator_top
// Piecewise-linear coil current waveform table with per-coil drive change
// and end-of-step current evaluation.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | tuser cmd; tdata point_index, coil_select, load_value,
//           |     | eval_time
//  m_axis   | out | tdata coil_number, drive_delta, end_current; tlast
//           |     | last_coil
//  cfg      | in  | cfg_we, cfg_index, cfg_data (no read-back)
//
// an evaluate beat yields one result per coil; each coil runs 5 samples
// (3 in backward mode), each one a clamp check and, unless it clamps, a
// segment scan over the points in use, then a read of the currents, the
// multiply, the 33-step serial divider and accumulation. a new beat is
// taken only once the sequencer is idle again.
// rst is synchronous; a stalled result holds in the output register while
// the sequencer waits. no clearing pass: the user must write table entries
// before they are read; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module coil_drive_waveform_interpolator_top #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_COILS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // point_index[3:0], coil_select[6:4], load_value[38:7], eval_time[69:39]
  input  wire logic [71:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // coil_number[2:0], drive_delta[37:3], end_current[69:38]
  output logic [71:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import cdwi_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;

  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.points <= 5'd2;
      cfg.coils  <= 4'd2;
      cfg.qstep  <= Q_W'(50);
      cfg.trap   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINTS: cfg.points <= cfg_data[4:0];
        REG_COILS:  cfg.coils  <= cfg_data[3:0];
        REG_QSTEP:  cfg.qstep  <= cfg_data[Q_W-1:0];
        REG_TRAP:   cfg.trap   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cdwi_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_COILS  (MAX_COILS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .stat     (stat),
    .in_fire  (in_fire),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  cdwi_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_COILS  (MAX_COILS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_fire  (in_fire),
    .in_cmd   (s_tuser),
    .in_point (s_tdata[3:0]),
    .in_coil  (s_tdata[6:4]),
    .in_value (s_tdata[38:7]),
    .in_time  (s_tdata[69:39]),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_data   (m_tdata),
    .m_last   (m_tlast)
  );

endmodule

`default_nettype wire

[verif/coil_drive_waveform_interpolator_top_test.sv]
// ----------------------------------------------------------------------------
// coil_drive_waveform_interpolator_top_test
// Fills the breakpoint table, then runs directed and random load and evaluate
// beats under several register settings and handshake idling patterns. Each
// result beat is compared with a local interpolation predictor, coil by coil.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coil_drive_waveform_interpolator_top_test;
  import cdwi_pkg::*;

  localparam int NPTS  = 16;
  localparam int NCOIL = 8;
  localparam int SPACE = 50000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  coil;
    logic [34:0] delta;
    logic [31:0] end_cur;
    logic        last;
  } coil_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // local copy of the table and the registers
  bit [30:0]   bp_time [NPTS];
  int          bp_cur [NCOIL][NPTS];
  int          npoints_reg;
  int          ncoils_reg;
  longint      qstep_reg;
  bit          trap_reg;

  coil_result_t pending_results[$];
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_off = 0;
  int  errors = 0;
  int  n_results = 0;
  int  n_evals = 0;
  int  n_loads = 0;

  coil_drive_waveform_interpolator_top dut (.*);

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("Verification failed");
    $finish;
  end

  // receiver side: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    coil_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h last %b", $time, m_tdata, m_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[2:0] !== exp_r.coil) begin
          errors++;
          $display("%0t: coil_number expected %0d actual %0d", $time, exp_r.coil,
                   m_tdata[2:0]);
        end
        if (m_tdata[37:3] !== exp_r.delta) begin
          errors++;
          $display("%0t: drive_delta expected %h actual %h", $time, exp_r.delta,
                   m_tdata[37:3]);
        end
        if (m_tdata[69:38] !== exp_r.end_cur) begin
          errors++;
          $display("%0t: end_current expected %h actual %h", $time, exp_r.end_cur,
                   m_tdata[69:38]);
        end
        if (m_tlast !== exp_r.last) begin
          errors++;
          $display("%0t: last_coil expected %b actual %b", $time, exp_r.last, m_tlast);
        end
      end
    end
  end

  function automatic longint current_at(int c, longint x);
    int n;
    longint t0, t1, v0, dv;
    longint unsigned mag, quo;
    n = npoints_reg < 2 ? 2 : (npoints_reg > NPTS ? NPTS : npoints_reg);
    if (x <= longint'(bp_time[0])) return longint'(bp_cur[c][0]);
    if (x >= longint'(bp_time[n-1])) return longint'(bp_cur[c][n-1]);
    for (int k = 0; k + 1 < n; k++) begin
      t0 = longint'(bp_time[k]);
      t1 = longint'(bp_time[k+1]);
      if (t0 <= x && x < t1) begin
        v0 = longint'(bp_cur[c][k]);
        dv = longint'(bp_cur[c][k+1]) - v0;
        mag = dv < 0 ? longint'(-dv) : dv;
        quo = (mag * longint'(x - t0)) / longint'(t1 - t0);
        return dv < 0 ? v0 - longint'(quo) : v0 + longint'(quo);
      end
    end
    return longint'(bp_cur[c][n-1]);
  endfunction

  // applies one accepted beat to the local table, queues coil results
  task automatic apply_beat(logic [1:0] cmd, logic [3:0] pt, logic [2:0] coil,
                            logic [31:0] val, logic [30:0] t);
    int nc;
    longint tt, i5, i3, d;
    coil_result_t r;
    tt = longint'(t);
    if (cmd == CMD_LOAD_TIME) begin
      bp_time[pt] = val[30:0];
      n_loads++;
    end else if (cmd == CMD_LOAD_CUR) begin
      bp_cur[coil][pt] = int'(val);
      n_loads++;
    end else if (cmd == CMD_EVAL) begin
      n_evals++;
      nc = ncoils_reg < 1 ? 1 : (ncoils_reg > NCOIL ? NCOIL : ncoils_reg);
      for (int j = 0; j < nc; j++) begin
        i5 = current_at(j, tt + 5 * qstep_reg);
        i3 = current_at(j, tt + 3 * qstep_reg);
        if (trap_reg)
          d = current_at(j, tt + qstep_reg) - current_at(j, tt - qstep_reg) + i5 - i3;
        else
          d = 2 * (i5 - i3);
        r.coil = j[2:0];
        r.delta = d[34:0];
        r.end_cur = 32'(current_at(j, tt + 4 * qstep_reg));
        r.last = (j + 1 == nc);
        pending_results.push_back(r);
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic [1:0] cmd, logic [3:0] pt, logic [2:0] coil,
                           logic [31:0] val, logic [30:0] t);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b0, t, val, coil, pt};
    do @(posedge clk); while (!s_tready);
    apply_beat(cmd, pt, coil, val, t);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_regs(int pts, int coils, int qs, bit trap);
    logic [23:0] vals [4];
    vals = '{pts[23:0], coils[23:0], qs[23:0], {23'b0, trap}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    npoints_reg = pts & 5'h1f;
    ncoils_reg = coils & 4'hf;
    qstep_reg = qs & 24'hffffff;
    trap_reg = trap;
  endtask

  task automatic eval_at(logic [30:0] t);
    send_beat(CMD_EVAL, 4'($urandom), 3'($urandom), $urandom, t);
  endtask

  function automatic logic [31:0] rand_current();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_table_fill;
    for (int p = 0; p < NPTS; p++)
      send_beat(CMD_LOAD_TIME, 4'(p), 3'($urandom),
                32'(p * SPACE + $urandom_range(SPACE / 2)), 31'd0);
    for (int c = 0; c < NCOIL; c++)
      for (int p = 0; p < NPTS; p++)
        send_beat(CMD_LOAD_CUR, 4'(p), 3'(c), rand_current(), 31'd0);
    drain();
  endtask

  task automatic test_directed;
    write_regs(NPTS, NCOIL, 1, 1'b1);
    eval_at(31'd0);
    eval_at(31'h7fff_ffff);
    eval_at(31'(3 * SPACE + 100));
    send_beat(CMD_UNUSED, 4'hf, 3'h7, 32'hffff_ffff, 31'h7fff_ffff);
    // extreme current swing on one segment
    send_beat(CMD_LOAD_CUR, 4'd1, 3'd0, 32'h8000_0000, 31'd0);
    send_beat(CMD_LOAD_CUR, 4'd2, 3'd0, 32'h7fff_ffff, 31'd0);
    eval_at(31'(bp_time[1] + 17));
    drain();
    write_regs(2, 1, 24'hffffff, 1'b0);
    eval_at(31'd0);
    eval_at(31'(SPACE));
    drain();
    // zero quarter step, out of range counts saturate
    write_regs(31, 15, 0, 1'b1);
    eval_at(31'(5 * SPACE + 3));
    drain();
    write_regs(0, 0, 9000, 1'b1);
    eval_at(31'(SPACE / 2));
    // negative time load keeps the low bits, then a non-monotonic table
    send_beat(CMD_LOAD_TIME, 4'd1, 3'd0, 32'hffff_fff0, 31'd0);
    eval_at(31'h7fff_fff8);
    eval_at(31'(SPACE));
    drain();
    write_regs(NPTS, 3, 7000, 1'b1);
    eval_at(31'(SPACE));
    send_beat(CMD_LOAD_TIME, 4'd1, 3'd0, 32'(SPACE + 1000), 31'd0);
    eval_at(31'(SPACE));
    drain();
  endtask

  task automatic random_beat;
    int sel;
    logic [3:0] pt;
    logic [31:0] v;
    logic [30:0] t;
    sel = $urandom_range(99);
    pt = 4'($urandom);
    if (sel < 20) begin
      v = ($urandom_range(9) == 0) ? $urandom : 32'(pt * SPACE + $urandom_range(SPACE - 1));
      send_beat(CMD_LOAD_TIME, pt, 3'($urandom), v, 31'($urandom));
    end else if (sel < 45) begin
      send_beat(CMD_LOAD_CUR, pt, 3'($urandom), rand_current(), 31'($urandom));
    end else if (sel < 50) begin
      send_beat(CMD_UNUSED, pt, 3'($urandom), $urandom, 31'($urandom));
    end else begin
      t = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(NPTS * SPACE + SPACE));
      eval_at(t);
    end
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    write_regs($urandom_range(31), ($urandom_range(3) == 0) ? $urandom_range(15)
               : $urandom_range(1, 4), $urandom_range(30000), $urandom_range(1));
    for (int i = 0; i < count; i++) begin
      random_beat();
      // sender waits for every result once, halfway through the phase
      if (i == count / 2) drain();
    end
    drain();
  endtask

  task automatic test_backpressure;
    idle_pct = 0;
    stall_pct = 0;
    write_regs(4, 2, 12000, 1'b1);
    hold_off = 4000;
    for (int i = 0; i < 8; i++) eval_at(31'($urandom_range(5 * SPACE)));
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    npoints_reg = 2;
    ncoils_reg = 2;
    qstep_reg = 50;
    trap_reg = 1'b1;
    @(negedge clk);
    test_table_fill();
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 25);
    test_random_phase(79, 0, 25);
    test_random_phase(0, 79, 25);
    test_random_phase(9, 9, 25);
    $display("covered %0d table loads, %0d evaluate beats, %0d coil results", n_loads,
             n_evals, n_results);
    $display("settings included saturated counts, zero and full quarter step, both modes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cdwi_pkg.sv
hw/rtl/cdwi_div.sv
hw/rtl/cdwi_dp.sv
hw/rtl/cdwi_ctrl.sv
hw/rtl/coil_drive_waveform_interpolator_top.sv
verif/coil_drive_waveform_interpolator_top_test.sv
